/* design/plbf_pkg.sv */
// Shared types and constants for the plate left/right boundary finder.
package plbf_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int SUM_BITS_DEF    = 20;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_FACTOR    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH_FRAC    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PLATE_HALF     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LARGE_HALF     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SMALL_HALF     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_HALF      = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOUNDARY_WIDTH = 3'd6;

  localparam logic [11:0] CLIP_FACTOR_RST    = 12'd435;
  localparam logic [8:0]  THRESH_FRAC_RST    = 9'd128;
  localparam logic [9:0]  PLATE_HALF_RST     = 10'd85;
  localparam logic [9:0]  LARGE_HALF_RST     = 10'd75;
  localparam logic [9:0]  SMALL_HALF_RST     = 10'd30;
  localparam logic [9:0]  STEP_HALF_RST      = 10'd25;
  localparam logic [9:0]  BOUNDARY_WIDTH_RST = 10'd50;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // store one column
    OP_DIV,       // one restoring-division step of the mean
    OP_CLIP,      // form the clip level
    OP_PREFIX,    // clip and accumulate one column
    OP_LARGE,     // large box at one index, track first max
    OP_SMALL,     // small box, track min/max
    OP_THRESH,    // form threshold
    OP_LSEARCH,   // left inward search step
    OP_RSEARCH,   // right inward search step
    OP_REFINE     // step filter at one index
  } op_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    op_t         op;
    logic        first;    // first element of a scan
    logic        right;    // refine: right edge (want max)
  } cmd_t;

  typedef struct packed {
    logic        hit;      // search found column above threshold
  } stat_t;

endpackage

/* design/plate_left_right_boundary_finder.sv */
// Top level: plate left/right boundary finder over a column edge profile.
//
// Channel  | valid      | stall      | payload
// in       | in_valid   | in_stall   | column_sum, last_column
// out      | out_valid  | out_stall  | left_column, right_column, column_mean_q8
// cfg      | cfg_write  | -          | cfg_index, cfg_data
//
// Columns load one per cycle while in_stall is low. The column flagged last
// starts the search: a mean divider (one quotient bit a cycle), the clip
// level, then scans over the prefix memory: prefix build, large smoothing,
// small smoothing over the plate window, the threshold, the inward searches
// one index at a time, and a refinement over the boundary window at each edge.
// Reset clears control state, counters and configuration registers;
// memories and the datapath registers are not cleared.
// in_stall is high while a search runs or a result waits; the result holds
// while out_stall is high.
module plate_left_right_boundary_finder #(
  parameter int MAX_COLUMNS = plbf_pkg::MAX_COLUMNS_DEF,
  parameter int SUM_BITS    = plbf_pkg::SUM_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [SUM_BITS-1:0]               column_sum,
  input  logic                              last_column,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [9:0]                        left_column,
  output logic [9:0]                        right_column,
  output logic [27:0]                       column_mean_q8,
  input  logic                              cfg_write,
  input  logic [plbf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [plbf_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import plbf_pkg::*;

  localparam int IDX_BITS = $clog2(MAX_COLUMNS);
  localparam int CNT_BITS = IDX_BITS + 1;
  localparam int TOT_BITS = SUM_BITS + IDX_BITS;
  localparam int MB       = TOT_BITS + 8;

  // Configuration registers.
  logic [11:0] clip_factor_q8;
  logic [8:0]  threshold_fraction_q8;
  logic [9:0]  plate_half_width, large_half_window, small_half_window;
  logic [9:0]  step_half_window, boundary_window_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_factor_q8        <= CLIP_FACTOR_RST;
      threshold_fraction_q8 <= THRESH_FRAC_RST;
      plate_half_width      <= PLATE_HALF_RST;
      large_half_window     <= LARGE_HALF_RST;
      small_half_window     <= SMALL_HALF_RST;
      step_half_window      <= STEP_HALF_RST;
      boundary_window_width <= BOUNDARY_WIDTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CLIP_FACTOR:    clip_factor_q8        <= cfg_data;
        REG_THRESH_FRAC:    threshold_fraction_q8 <= cfg_data[8:0];
        REG_PLATE_HALF:     plate_half_width      <= cfg_data[9:0];
        REG_LARGE_HALF:     large_half_window     <= cfg_data[9:0];
        REG_SMALL_HALF:     small_half_window     <= cfg_data[9:0];
        REG_STEP_HALF:      step_half_window      <= cfg_data[9:0];
        REG_BOUNDARY_WIDTH: boundary_window_width <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Column count and raw total.
  logic [CNT_BITS-1:0] column_count;
  logic [TOT_BITS-1:0] raw_total;
  logic in_go, busy, done, clear;
  cmd_t cmd;
  stat_t stat;
  logic signed [CNT_BITS+1:0] idx, peak;
  logic [MB-1:0] mean_q8;
  logic [9:0] left_q, right_q;
  logic store_ok;

  assign in_stall = busy;
  assign in_go    = in_valid && !busy;
  assign store_ok = column_count < CNT_BITS'(MAX_COLUMNS);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      column_count <= '0;
      raw_total    <= '0;
    end else if (in_go && store_ok) begin
      column_count <= column_count + 1'b1;
      raw_total    <= raw_total + TOT_BITS'(column_sum);
    end
  end

  plbf_datapath #(
    .MAX_COLUMNS(MAX_COLUMNS), .SUM_BITS(SUM_BITS)
  ) u_dp (
    .clk(clk), .cmd(cmd),
    .load_addr(column_count[IDX_BITS-1:0]),
    .load_data(column_sum),
    .count(column_count), .total(raw_total), .idx(idx),
    .clip_factor(clip_factor_q8), .thresh_frac(threshold_fraction_q8),
    .large_half(large_half_window), .small_half(small_half_window),
    .step_half(step_half_window),
    .stat(stat), .mean_q8(mean_q8), .peak(peak)
  );

  // Loads beyond the store are dropped by gating the command.
  cmd_t cmd_c;
  always_comb begin
    cmd = cmd_c;
    if (cmd_c.op == OP_LOAD && !store_ok) cmd.op = OP_NONE;
  end

  plbf_controller #(.CNT_BITS(CNT_BITS), .MB(MB)) u_ctl (
    .clk(clk), .rst(rst), .in_go(in_go), .in_last(last_column),
    .count(column_count), .plate_half(plate_half_width),
    .bwidth(boundary_window_width), .stat(stat), .peak(peak),
    .out_taken(!out_stall), .cmd(cmd_c), .idx(idx), .busy(busy),
    .done(done), .left_q(left_q), .right_q(right_q), .clear(clear)
  );

  assign out_valid      = done;
  assign left_column    = left_q;
  assign right_column   = right_q;
  assign column_mean_q8 = mean_q8[27:0];

  // A result only after a search has run; no input taken while busy.
  a_no_in_when_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    column_count <= CNT_BITS'(MAX_COLUMNS)) else $error("column count overflow");
  a_clear_after: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> (column_count == '0 && !out_valid))
    else $error("state not cleared after result");

endmodule

/* design/plbf_datapath.sv */
// Datapath: column and prefix memories, divider, scan arithmetic.
module plbf_datapath #(
  parameter int MAX_COLUMNS = plbf_pkg::MAX_COLUMNS_DEF,
  parameter int SUM_BITS    = plbf_pkg::SUM_BITS_DEF,
  parameter int IDX_BITS    = $clog2(MAX_COLUMNS),
  parameter int CNT_BITS    = IDX_BITS + 1,
  parameter int TOT_BITS    = SUM_BITS + IDX_BITS
) (
  input  logic                          clk,
  input  plbf_pkg::cmd_t                cmd,
  input  logic [IDX_BITS-1:0]           load_addr,
  input  logic [SUM_BITS-1:0]           load_data,
  input  logic [CNT_BITS-1:0]           count,
  input  logic [TOT_BITS-1:0]           total,
  input  logic signed [CNT_BITS+1:0]    idx,
  input  logic [11:0]                   clip_factor,
  input  logic [8:0]                    thresh_frac,
  input  logic [9:0]                    large_half,
  input  logic [9:0]                    small_half,
  input  logic [9:0]                    step_half,
  output plbf_pkg::stat_t               stat,
  output logic [TOT_BITS+7:0]           mean_q8,
  output logic signed [CNT_BITS+1:0]    peak
);
  import plbf_pkg::*;

  localparam int MB = TOT_BITS + 8;            // mean / dividend width
  localparam int PB = TOT_BITS;                // prefix width
  localparam int SB = PB + 2;                  // signed box/step width
  localparam int DB = SB + 10;                 // threshold width
  localparam int XB = CNT_BITS + 2;            // signed index width

  logic [SUM_BITS-1:0] column_store [MAX_COLUMNS];
  logic [PB-1:0]       prefix_store [MAX_COLUMNS];
  // Second copy of the prefix sums, read only at the center index.
  logic [PB-1:0]       prefix_mirror [MAX_COLUMNS];

  // Division state (restoring, one quotient bit per step).
  logic [MB-1:0] rem, quo;
  logic [SUM_BITS+7:0] clip;
  logic [PB-1:0] run;
  logic [MB+11:0] clip_prod;
  logic signed [SB-1:0] best, smin, smax;
  logic signed [DB-1:0] thr;

  // Prefix lookup with border rules; combinational read of the array is
  // avoided: the read data is registered in a memory read stage.
  function automatic logic [IDX_BITS-1:0] ix(input logic signed [XB-1:0] a);
    return a[IDX_BITS-1:0];
  endfunction

  logic signed [XB-1:0] hi_i, lo_i, ctr_i;
  logic [9:0] half_sel;
  always_comb begin
    unique case (cmd.op)
      OP_LARGE: half_sel = large_half;
      OP_REFINE: half_sel = step_half;
      default: half_sel = small_half;
    endcase
    if (cmd.op == OP_REFINE) begin
      hi_i = idx + XB'(half_sel);
      lo_i = idx - XB'(half_sel);
    end else begin
      hi_i = idx + XB'(half_sel);
      lo_i = idx - XB'(half_sel) - XB'(1);
    end
    ctr_i = idx;
  end

  // Stage 1: registered reads (two read ports on the prefix memory, one on
  // its copy). Past the end, the running total stands in for the last entry.
  logic [PB-1:0] rd_hi, rd_lo, rd_c;
  logic hi_clamp, lo_zero;
  logic [PB-1:0] rd_col;
  plbf_pkg::cmd_t cmd_q;
  logic signed [XB-1:0] idx_q;
  logic [SUM_BITS-1:0] col_q;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) column_store[load_addr] <= load_data;
    col_q <= column_store[ix(idx)];
    rd_hi <= prefix_store[ix(hi_i)];
    rd_lo <= prefix_store[ix(lo_i)];
    rd_c  <= prefix_mirror[ix(ctr_i)];
    hi_clamp <= hi_i >= XB'(count);
    lo_zero  <= lo_i < 0;
    cmd_q <= cmd;
    idx_q <= idx;
  end

  logic [PB-1:0] p_hi, p_lo;
  logic signed [SB-1:0] val;
  always_comb begin
    p_hi = hi_clamp ? run : rd_hi;
    p_lo = lo_zero ? '0 : rd_lo;
    if (cmd_q.op == OP_REFINE)
      val = (SB'(rd_c) <<< 1) - SB'(p_lo) - SB'(p_hi);
    else
      val = SB'(p_hi) - SB'(p_lo);
  end

  logic [SUM_BITS-1:0] col_clip;
  logic [PB-1:0] run_next;
  always_comb begin
    col_clip = ({8'd0, col_q} > clip) ? clip[SUM_BITS-1:0] : col_q;
    run_next = run + PB'(col_clip);
  end
  assign rd_col = run_next;

  logic signed [DB-1:0] val256;
  assign val256 = DB'(val) <<< 8;
  logic signed [DB-1:0] thr_calc;
  logic signed [SB-1:0] sdiff;
  assign sdiff = smax - smin;
  assign clip_prod = MB'(mean_q8) * 12'(clip_factor) ;

  logic [MB:0] trial;
  assign trial = {rem, quo[MB-1]} - {{(MB+1-CNT_BITS){1'b0}}, count};

  always_ff @(posedge clk) begin
    stat.hit <= 1'b0;
    unique case (cmd.op)
      OP_DIV: begin
        if (cmd.first) begin
          rem <= '0;
          quo <= {total, 8'd0};
        end else if (!trial[MB]) begin
          rem <= trial[MB-1:0];
          quo <= {quo[MB-2:0], 1'b1};
        end else begin
          rem <= {rem[MB-2:0], quo[MB-1]};
          quo <= {quo[MB-2:0], 1'b0};
        end
      end
      OP_CLIP: begin
        mean_q8 <= quo;
        run <= '0;
      end
      default: ;
    endcase
    if (cmd.op == OP_CLIP && !cmd.first)
      clip <= (SUM_BITS+8)'(clip_prod >> 16) > {8'd0, {SUM_BITS{1'b1}}} ?
              {8'd0, {SUM_BITS{1'b1}}} : (SUM_BITS+8)'(clip_prod >> 16);
    unique case (cmd_q.op)
      OP_PREFIX: begin
        run <= rd_col;
        prefix_store[ix(idx_q)] <= rd_col;
        prefix_mirror[ix(idx_q)] <= rd_col;
      end
      OP_LARGE: begin
        if (cmd_q.first || val > best) begin
          best <= val;
          peak <= idx_q;
        end
      end
      OP_SMALL: begin
        if (cmd_q.first) begin
          smin <= val;
          smax <= val;
        end else begin
          if (val > smax) smax <= val;
          if (val < smin) smin <= val;
        end
      end
      OP_THRESH: thr <= thr_calc;
      OP_LSEARCH, OP_RSEARCH: stat.hit <= val256 > thr;
      OP_REFINE: begin
        if (cmd_q.first || (cmd_q.right ? val > best : val < best)) begin
          best <= val;
          peak <= idx_q;
        end
      end
      default: ;
    endcase
  end
  assign thr_calc = (DB'(smin) <<< 8) + DB'($signed({1'b0, thresh_frac})) * DB'(sdiff);

endmodule

/* design/plbf_controller.sv */
// Controller: sequences load, mean, prefix, smoothing, search and refine scans.
module plbf_controller #(
  parameter int CNT_BITS = 11,
  parameter int MB       = 38
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_go,
  input  logic                       in_last,
  input  logic [CNT_BITS-1:0]        count,
  input  logic [9:0]                 plate_half,
  input  logic [9:0]                 bwidth,
  input  plbf_pkg::stat_t            stat,
  input  logic signed [CNT_BITS+1:0] peak,
  input  logic                       out_taken,
  output plbf_pkg::cmd_t             cmd,
  output logic signed [CNT_BITS+1:0] idx,
  output logic                       busy,
  output logic                       done,
  output logic [9:0]                 left_q,
  output logic [9:0]                 right_q,
  output logic                       clear
);
  import plbf_pkg::*;

  localparam int XB = CNT_BITS + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_CLIP, S_PREFIX, S_LARGE, S_SMALL, S_THRESH,
    S_LSEARCH, S_RSEARCH, S_REFINE_L, S_REFINE_R, S_OUT
  } state_t;

  state_t state;
  logic signed [XB-1:0] cl, cr, lo, hi, edge_l, edge_r, last_i;
  logic [$clog2(MB+2)-1:0] steps;
  logic [1:0] drain;
  logic first;
  logic signed [XB-1:0] halfb;
  logic signed [XB-1:0] phs;

  assign last_i = XB'(count) - XB'(1);
  assign halfb  = XB'(bwidth[9:1]);
  assign phs    = XB'(plate_half);

  always_comb begin
    cmd.first = first;
    cmd.right = (state == S_REFINE_R);
    unique case (state)
      S_DIV:      cmd.op = OP_DIV;
      S_CLIP:     cmd.op = OP_CLIP;
      S_PREFIX:   cmd.op = (drain == 2'd0) ? OP_PREFIX : OP_NONE;
      S_LARGE:    cmd.op = (drain == 2'd0) ? OP_LARGE : OP_NONE;
      S_SMALL:    cmd.op = (drain == 2'd0) ? OP_SMALL : OP_NONE;
      S_THRESH:   cmd.op = (drain == 2'd0) ? OP_THRESH : OP_NONE;
      S_LSEARCH:  cmd.op = (drain == 2'd0) ? OP_LSEARCH : OP_NONE;
      S_RSEARCH:  cmd.op = (drain == 2'd0) ? OP_RSEARCH : OP_NONE;
      S_REFINE_L, S_REFINE_R: cmd.op = (drain == 2'd0) ? OP_REFINE : OP_NONE;
      default:    cmd.op = in_go ? OP_LOAD : OP_NONE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);
  assign clear = (state == S_OUT) && out_taken;

  // drain: wait states at scan ends for the registered read and the registered compute.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      drain <= '0;
      first <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_go && in_last) begin
          state <= S_DIV; first <= 1'b1; steps <= '0;
        end
        S_DIV: begin
          first <= 1'b0;
          steps <= steps + 1'b1;
          if (!first && steps == ($clog2(MB+2))'(MB)) begin
            state <= S_CLIP; first <= 1'b1;
          end
        end
        S_CLIP: begin
          // with first set, latch the mean; then form the clip level
          if (first) first <= 1'b0;
          else begin state <= S_PREFIX; idx <= '0; drain <= '0; end
        end
        S_PREFIX: begin
          if (drain != 2'd0) begin
            drain <= drain - 1'b1;
            if (drain == 2'd1) begin state <= S_LARGE; idx <= '0; first <= 1'b1; end
          end else if (idx == last_i) drain <= 2'd2;
          else idx <= idx + 1'b1;
        end
        S_LARGE: begin
          if (drain != 2'd0) begin
            drain <= drain - 1'b1;
            if (drain == 2'd1) begin
              cl <= (peak - phs < 0) ? '0 : peak - phs;
              cr <= (peak + phs > last_i) ? last_i : peak + phs;
              idx <= (peak - phs < 0) ? '0 : peak - phs;
              state <= S_SMALL; first <= 1'b1;
            end
          end else begin
            first <= 1'b0;
            if (idx == last_i) drain <= 2'd2;
            else idx <= idx + 1'b1;
          end
        end
        S_SMALL: begin
          if (drain != 2'd0) begin
            drain <= drain - 1'b1;
            if (drain == 2'd1) begin state <= S_THRESH; first <= 1'b0; end
          end else begin
            first <= 1'b0;
            if (idx >= cr) drain <= 2'd2;
            else idx <= idx + 1'b1;
          end
        end
        S_THRESH: begin
          if (drain == 2'd0) drain <= 2'd2;
          else begin
            drain <= drain - 1'b1;
            if (drain == 2'd1) begin state <= S_LSEARCH; idx <= cl; end
          end
        end
        // Search one index at a time: issue, then wait for the hit flag.
        S_LSEARCH: begin
          if (drain == 2'd0) drain <= 2'd2;
          else begin
            drain <= drain - 1'b1;
            if (drain == 2'd1) begin
              if (stat.hit) begin edge_l <= idx; state <= S_RSEARCH; idx <= cr; end
              else if (idx == last_i) begin edge_l <= -XB'(1); state <= S_RSEARCH; idx <= cr; end
              else idx <= idx + 1'b1;
            end
          end
        end
        S_RSEARCH: begin
          if (drain == 2'd0) drain <= 2'd2;
          else begin
            drain <= drain - 1'b1;
            if (drain == 2'd1) begin
              if (stat.hit || idx == '0) begin
                edge_r <= stat.hit ? idx : -XB'(1);
                lo <= (edge_l - halfb < 0) ? '0 : edge_l - halfb;
                hi <= (edge_l + halfb > last_i) ? last_i : edge_l + halfb;
                idx <= (edge_l - halfb < 0) ? '0 : edge_l - halfb;
                state <= S_REFINE_L; first <= 1'b1;
              end else idx <= idx - 1'b1;
            end
          end
        end
        S_REFINE_L, S_REFINE_R: begin
          if (hi < lo) begin
            if (state == S_REFINE_L) begin
              left_q <= lo[9:0];
              lo <= (edge_r - halfb < 0) ? '0 : edge_r - halfb;
              hi <= (edge_r + halfb > last_i) ? last_i : edge_r + halfb;
              idx <= (edge_r - halfb < 0) ? '0 : edge_r - halfb;
              state <= S_REFINE_R; first <= 1'b1;
            end else begin right_q <= lo[9:0]; state <= S_OUT; end
          end else if (drain != 2'd0) begin
            drain <= drain - 1'b1;
            if (drain == 2'd1) begin
              if (state == S_REFINE_L) begin
                left_q <= peak[9:0];
                lo <= (edge_r - halfb < 0) ? '0 : edge_r - halfb;
                hi <= (edge_r + halfb > last_i) ? last_i : edge_r + halfb;
                idx <= (edge_r - halfb < 0) ? '0 : edge_r - halfb;
                state <= S_REFINE_R; first <= 1'b1;
              end else begin right_q <= peak[9:0]; state <= S_OUT; end
            end
          end else begin
            first <= 1'b0;
            if (idx >= hi) drain <= 2'd2;
            else idx <= idx + 1'b1;
          end
        end
        S_OUT: if (out_taken) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
